[design/coin_change_dispenser_defines.svh]
// assertion macros for the coin change dispenser
`ifndef COIN_CHANGE_DISPENSER_DEFINES_SVH
`define COIN_CHANGE_DISPENSER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define CCD_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define CCD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

[design/ccd_pkg.sv]
// shared widths and types for the coin change dispenser
package ccd_pkg;
    localparam int AMT_W = 24;
    localparam int DEN_W = 16;
    localparam int SLOT_W = 3;

    typedef logic [AMT_W-1:0] t_amount;
    typedef logic [DEN_W-1:0] t_denom;

    typedef struct packed {
        logic [SLOT_W-1:0] coin_slot;
        t_amount           coin_count;
        logic              unpayable;
        logic              last_result;
    } t_result;

    // divider handshake
    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic done;
    } t_div_rsp;
endpackage

[design/ccd_in_if.sv]
// input channel interface
interface ccd_in_if;
    import ccd_pkg::*;
    logic    valid;
    logic    ready;
    t_amount amount_cents;
    modport source (output valid, output amount_cents, input ready);
    modport sink (input valid, input amount_cents, output ready);
endinterface

[design/ccd_out_if.sv]
// output channel interface
interface ccd_out_if;
    import ccd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [SLOT_W-1:0]       coin_slot;
    t_amount                 coin_count;
    logic                    unpayable;
    logic                    last_result;
    modport source (output valid, output coin_slot, output coin_count,
                    output unpayable, output last_result, input ready);
    modport sink (input valid, input coin_slot, input coin_count,
                  input unpayable, input last_result, output ready);
endinterface

[design/ccd_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
module ccd_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ccd_pkg::t_div_req i_req,
    input  ccd_pkg::t_amount i_dividend,
    input  ccd_pkg::t_denom  i_divisor,
    output ccd_pkg::t_div_rsp o_rsp,
    output ccd_pkg::t_amount o_quot,
    output ccd_pkg::t_amount o_rem
);
    import ccd_pkg::*;

    localparam int CW = $clog2(AMT_W + 1);

    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_amount          r_q, n_q;
    logic [DEN_W:0]   r_r, n_r;
    t_denom           r_d, n_d;
    logic [DEN_W+1:0] w_trial;
    logic [DEN_W:0]   w_shift;

    // one shift and trial subtract per cycle
    always_comb begin
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        n_q = r_q; n_r = r_r; n_d = r_d;
        w_shift = {r_r[DEN_W-1:0], r_q[AMT_W-1]};
        w_trial = {1'b0, w_shift} - {2'b00, r_d};
        if (i_req.start) begin
            n_q = i_dividend; n_r = '0; n_d = i_divisor;
            n_cnt = CW'(AMT_W); n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[DEN_W+1]) begin
                n_r = w_trial[DEN_W:0];
                n_q = {r_q[AMT_W-2:0], 1'b1};
            end else begin
                n_r = w_shift;
                n_q = {r_q[AMT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r; r_d <= n_d;
    end

    assign o_rsp.done = r_done;
    assign o_quot = r_q;
    assign o_rem = {{(AMT_W-DEN_W-1){1'b0}}, r_r};
endmodule

[design/coin_change_dispenser.sv]
// coin change dispenser top level: sequencer around a serial divider
// each amount runs a series of divides, then emits one result item per
// used slot of the denomination list
// throughput: one amount at a time, set by the shared 24-step divider
// reset: synchronous active low, denomination registers return to 25, 10, 5, 1, then 0
// a result item is held in an output register and the next input waits
module coin_change_dispenser #(
    parameter int MAX_DENOMS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_index,
    input  logic [ccd_pkg::DEN_W-1:0]      i_cfg_data,
    ccd_in_if.sink                         in_ch,
    ccd_out_if.source                      out_ch
);
    import ccd_pkg::*;
    `include "coin_change_dispenser_defines.svh"

    localparam int NR = (MAX_DENOMS < 8) ? MAX_DENOMS : 8;
    localparam int IW = $clog2(NR + 1);
    localparam int XW = (NR > 1) ? $clog2(NR) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_PRE, S_BIG, S_T1, S_T2, S_FIN, S_OUT, S_WAIT
    } t_state;

    t_denom            r_den [NR];
    t_state            r_st;
    t_amount           r_rem, r_trem, r_tot1, r_tot2, r_amt;
    t_amount           r_cnt [NR];
    logic [IW-1:0]     r_i, r_len, r_b;
    logic              r_go, r_started, r_unp;
    t_result           r_res;
    logic              r_ovalid;
    t_div_req          w_req;
    t_div_rsp          w_rsp;
    t_amount           w_q, w_r, w_div_a;
    t_denom            w_div_d;
    logic [XW-1:0]     w_ix;
    logic [DEN_W:0]    w_two;

    assign w_ix = r_i[XW-1:0];
    assign w_two = {r_den[r_b[XW-1:0]], 1'b0};

    ccd_div u_div (
        .i_clk, .i_rst_n, .i_req(w_req), .i_dividend(w_div_a),
        .i_divisor(w_div_d), .o_rsp(w_rsp), .o_quot(w_q), .o_rem(w_r)
    );

    // divider operand selection
    always_comb begin
        w_req.start = r_go;
        w_div_d = r_den[w_ix];
        w_div_a = (r_st == S_T1 || r_st == S_T2) ? r_trem : r_rem;
        if (r_st == S_BIG) begin
            w_div_d = r_den[r_b[XW-1:0]];
            w_div_a = r_rem - AMT_W'(w_two);
        end
    end

    assign in_ch.ready = (r_st == S_IDLE) && !r_ovalid;
    assign out_ch.valid = r_ovalid;
    assign out_ch.coin_slot = r_res.coin_slot;
    assign out_ch.coin_count = r_res.coin_count;
    assign out_ch.unpayable = r_res.unpayable;
    assign out_ch.last_result = r_res.last_result;

    // sequencer: scan list, greedy divides, trials, emit counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_go <= 1'b0; r_ovalid <= 1'b0;
            for (int k = 0; k < NR; k++)
                r_den[k] <= (k == 0) ? 16'd25 : (k == 1) ? 16'd10 :
                            (k == 2) ? 16'd5 : (k == 3) ? 16'd1 : 16'd0;
        end else begin
            r_go <= 1'b0;
            if (i_cfg_we && 32'(i_cfg_index) < NR)
                r_den[i_cfg_index[XW-1:0]] <= i_cfg_data;
            if (out_ch.ready && r_ovalid) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (in_ch.valid && !r_ovalid) begin
                    r_amt <= in_ch.amount_cents; r_rem <= in_ch.amount_cents;
                    r_i <= '0; r_len <= '0; r_b <= '0; r_started <= 1'b0;
                    for (int k = 0; k < NR; k++) r_cnt[k] <= '0;
                    r_st <= S_SCAN;
                end
                S_SCAN: begin
                    // one position a cycle: length and first tight pair
                    if (r_i < IW'(NR) && r_den[w_ix] != '0) begin
                        r_len <= r_i + 1'b1;
                        if (r_i != '0 && !r_started &&
                            {1'b0, r_den[w_ix - 1'b1]} < {r_den[w_ix], 1'b0}) begin
                            r_b <= r_i - 1'b1; r_started <= 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        if (!r_started) r_b <= r_i;
                        r_i <= '0;
                        if (r_i == '0) begin
                            r_res <= '{'0, '0, r_amt != '0, 1'b1};
                            r_ovalid <= 1'b1; r_st <= S_WAIT;
                        end else begin
                            r_st <= S_PRE; r_go <= 1'b1;
                        end
                    end
                end
                S_PRE: begin
                    // greedy above b, or everything when no tight pair
                    if (!r_started && r_i == r_len) begin
                        r_st <= S_FIN;
                    end else if (r_started && r_i == r_b) begin
                        if (r_rem >= AMT_W'(w_two)) begin
                            r_st <= S_BIG; r_go <= 1'b1;
                        end else begin
                            r_trem <= r_rem; r_tot1 <= '0; r_st <= S_T1; r_go <= 1'b1;
                        end
                    end else if (w_rsp.done) begin
                        r_cnt[w_ix] <= w_q; r_rem <= w_r;
                        r_i <= r_i + 1'b1;
                        // no divide after the last slot of a plain greedy pass
                        if (r_started || r_i + 1'b1 != r_len) r_go <= 1'b1;
                    end
                end
                S_BIG: if (w_rsp.done) begin
                    r_cnt[r_b[XW-1:0]] <= w_q + 1'b1;
                    r_rem <= w_r + AMT_W'(r_den[r_b[XW-1:0]]);
                    r_trem <= w_r + AMT_W'(r_den[r_b[XW-1:0]]);
                    r_tot1 <= '0; r_st <= S_T1; r_go <= 1'b1;
                end
                S_T1: if (w_rsp.done) begin
                    // trial from b
                    r_tot1 <= r_tot1 + w_q; r_go <= 1'b1;
                    if (r_i + 1'b1 == r_len) begin
                        r_trem <= r_rem; r_tot2 <= '0;
                        if (r_b + 1'b1 == r_len) begin
                            r_i <= r_b; r_st <= S_FIN;
                        end else begin
                            r_i <= r_b + 1'b1; r_st <= S_T2;
                        end
                    end else begin
                        r_trem <= w_r; r_i <= r_i + 1'b1;
                    end
                end
                S_T2: if (w_rsp.done) begin
                    // trial from b+1
                    r_tot2 <= r_tot2 + w_q; r_trem <= w_r;
                    if (r_i + 1'b1 == r_len) begin
                        r_i <= (r_tot1 > r_tot2 + w_q) ? r_b + 1'b1 : r_b;
                        r_st <= S_FIN; r_go <= 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1; r_go <= 1'b1;
                    end
                end
                S_FIN: begin
                    // final greedy pass, then emit
                    if (r_i == r_len) begin
                        r_unp <= r_rem != '0; r_i <= '0; r_st <= S_OUT;
                    end else if (w_rsp.done) begin
                        r_cnt[w_ix] <= r_cnt[w_ix] + w_q; r_rem <= w_r;
                        r_i <= r_i + 1'b1;
                        if (r_i + 1'b1 != r_len) r_go <= 1'b1;
                    end
                end
                S_OUT: if (!r_ovalid || out_ch.ready) begin
                    r_res <= '{SLOT_W'(r_i), r_cnt[w_ix], r_unp, r_i + 1'b1 == r_len};
                    r_ovalid <= 1'b1;
                    r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 == r_len) r_st <= S_WAIT;
                end
                S_WAIT: if (!r_ovalid || out_ch.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `CCD_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_st != S_IDLE, !in_ch.ready)
    `CCD_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, r_ovalid && !out_ch.ready, r_ovalid)
    `CCD_ASSERT_IMP(a_last_ends, i_clk, i_rst_n, r_ovalid && r_res.last_result,
        r_st == S_WAIT || r_st == S_IDLE)
endmodule
